// ===== rtl/bam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap allocation map package
// Shared types, codes and constants of the bitmap allocation map.
// ----------------------------------------------------------------------------
package bam_pkg;

  // Default size of the map in bytes.
  localparam int MAP_BYTES_DEF = 64;

  // Reset value of the bytes-in-use register.
  localparam logic [6:0] BYTES_IN_USE_RST = 7'd64;

  // The position fields reach 512 bits, so a find never looks past 64 bytes.
  localparam int SCAN_BYTES_MAX = 64;

  typedef enum logic [1:0] {
    MODE_TEST  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_FIND  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] bit_pos;
  } byte_find_t;

  // Lowest bit of a byte that is set.
  function automatic byte_find_t first_one(input logic [7:0] value);
    byte_find_t res;
    res.hit     = 1'b0;
    res.bit_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (value[i]) begin
        res.hit     = 1'b1;
        res.bit_pos = 3'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bitmap_allocation_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap allocation map
// Bit map held in a byte-wide RAM; test, set, clear and find-first operations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream, one operation per transaction, and each
//   request gives exactly one response transaction on the out_ stream. The
//   cfg_ channel writes the bytes-in-use register and is always ready.
//   Test, set and clear pass from acceptance to a loaded response through
//   a RAM read, a read-modify-write step and the load of the output
//   register. A find reads one map byte per cycle from the RAM read port,
//   up to scan length bytes, scan length being the smaller of bytes in
//   use, MAP_BYTES and 64. One request is in flight at a time; a new
//   request is taken as soon as the previous response sits in the output
//   register, even while that response is still waiting.
//   After reset the block sweeps the RAM to zero, one byte per cycle, so
//   in_tready stays low until the sweep ends; bytes in use resets to 64.
//   When the receiver stalls, the response is held in the output register,
//   and a following request finishes its work and then waits for that
//   register to drain.
// ----------------------------------------------------------------------------
module bitmap_allocation_map #(
  parameter int MAP_BYTES = bam_pkg::MAP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [1:0] mode, [10:2] position, [11] find_value
  // Response stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata, // [1:0] status, [2] bit_value, [11:3] found_position
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data   // bytes_in_use
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  // Largest number of bytes that a find may visit.
  localparam logic [6:0] SCAN_CAP = (MAP_BYTES < bam_pkg::SCAN_BYTES_MAX) ?
                                    7'(MAP_BYTES) : 7'(bam_pkg::SCAN_BYTES_MAX);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  // Request fields.
  bam_pkg::mode_t in_mode;
  logic [8:0]     in_position;
  logic           in_find_value;

  assign in_mode       = bam_pkg::mode_t'(in_tdata[1:0]);
  assign in_position   = in_tdata[10:2];
  assign in_find_value = in_tdata[11];

  // Control and payload registers.
  bam_pkg::state_t  state_r, state_nxt;
  logic [6:0]       bytes_in_use_r;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [6:0]       issue_cnt_r, issue_cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [5:0]       pend_idx_r, pend_idx_nxt;
  logic [6:0]       scan_len_r, scan_len_nxt;
  bam_pkg::mode_t   mode_r, mode_nxt;
  logic [2:0]       bit_sel_r, bit_sel_nxt;
  logic             want_r, want_nxt;
  bam_pkg::status_t res_status_r, res_status_nxt;
  logic             res_bit_r, res_bit_nxt;
  logic [8:0]       res_found_r, res_found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_data_r, out_data_nxt;

  // RAM ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic                 in_fire;
  logic [6:0]           scan_len;
  logic                 in_range;
  logic                 out_free;
  bam_pkg::byte_find_t  scan_hit;

  // Bytes in use, bounded by the map and by the reach of the position field.
  // Because a byte index is below 64, the same bound serves the range check.
  assign scan_len  = (bytes_in_use_r > SCAN_CAP) ? SCAN_CAP : bytes_in_use_r;
  assign in_range  = ({1'b0, in_position[8:3]} < scan_len);
  assign in_tready = (state_r == bam_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Searching for a zero is searching for a one in the inverted byte.
  assign scan_hit = bam_pkg::first_one(want_r ? mem_rdata : ~mem_rdata);

  bam_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bam_pkg::ST_CLEAR;
      clr_cnt_r      <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      bytes_in_use_r <= bam_pkg::BYTES_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bytes_in_use_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_cnt_r  <= issue_cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    scan_len_r   <= scan_len_nxt;
    mode_r       <= mode_nxt;
    bit_sel_r    <= bit_sel_nxt;
    want_r       <= want_nxt;
    res_status_r <= res_status_nxt;
    res_bit_r    <= res_bit_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    issue_cnt_nxt  = issue_cnt_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    scan_len_nxt   = scan_len_r;
    mode_nxt       = mode_r;
    bit_sel_nxt    = bit_sel_r;
    want_nxt       = want_r;
    res_status_nxt = res_status_r;
    res_bit_nxt    = res_bit_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt_r;
    mem_wdata      = 8'd0;
    mem_re         = 1'b0;
    mem_raddr      = AW'(in_position[8:3]);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bam_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = bam_pkg::ST_IDLE;
        end
      end

      bam_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_nxt       = in_mode;
          bit_sel_nxt    = in_position[2:0];
          want_nxt       = in_find_value;
          res_status_nxt = bam_pkg::STAT_OK;
          res_bit_nxt    = 1'b0;
          res_found_nxt  = 9'd0;
          if (in_mode == bam_pkg::MODE_FIND) begin
            issue_cnt_nxt = 7'd0;
            scan_len_nxt  = scan_len;
            state_nxt     = bam_pkg::ST_SCAN;
          end else if (in_range) begin
            mem_re    = 1'b1;
            state_nxt = bam_pkg::ST_MOD;
          end else begin
            res_status_nxt = bam_pkg::STAT_RANGE;
            state_nxt      = bam_pkg::ST_DONE;
          end
        end
      end

      bam_pkg::ST_MOD: begin
        // The byte read last cycle is in mem_rdata; write back the update.
        mem_waddr = AW'(pend_idx_r);
        case (mode_r)
          bam_pkg::MODE_TEST: begin
            res_bit_nxt = mem_rdata[bit_sel_r];
          end
          bam_pkg::MODE_SET: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | (8'd1 << bit_sel_r);
          end
          bam_pkg::MODE_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~(8'd1 << bit_sel_r);
          end
          default: begin
            res_bit_nxt = 1'b0;
          end
        endcase
        state_nxt = bam_pkg::ST_DONE;
      end

      bam_pkg::ST_SCAN: begin
        // One byte read issued per cycle; the byte issued last cycle is checked.
        mem_raddr = AW'(issue_cnt_r);
        if (pend_r && scan_hit.hit) begin
          res_found_nxt = {pend_idx_r, scan_hit.bit_pos};
          state_nxt     = bam_pkg::ST_DONE;
        end else if (issue_cnt_r < scan_len_r) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = issue_cnt_r[5:0];
          issue_cnt_nxt = issue_cnt_r + 7'd1;
        end else if (!pend_r) begin
          res_status_nxt = bam_pkg::STAT_NOT_FOUND;
          state_nxt      = bam_pkg::ST_DONE;
        end
      end

      bam_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, res_found_r, res_bit_r, res_status_r};
          state_nxt     = bam_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bam_pkg::ST_IDLE;
      end
    endcase

    // Remember the byte index of a test, set or clear for its write-back.
    if (state_r == bam_pkg::ST_IDLE && in_fire) begin
      pend_idx_nxt = in_position[8:3];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Only one request is in flight: acceptance closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another was in flight");

  // A failed operation reports neither a bit value nor a position.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != bam_pkg::STAT_OK |-> out_tdata[11:2] == 10'd0)
    else $error("failed response carries data");

  // The map is only written by the clearing sweep and by set or clear.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == bam_pkg::ST_CLEAR ||
               (state_r == bam_pkg::ST_MOD &&
                (mode_r == bam_pkg::MODE_SET || mode_r == bam_pkg::MODE_CLEAR)))
    else $error("unexpected map write");

  // A find never reads beyond the bytes it may visit.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bam_pkg::ST_SCAN && mem_re |-> issue_cnt_r < scan_len_r)
    else $error("find read beyond the bytes in use");

  // Status is never the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// ===== rtl/bam_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap allocation map RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== test/bitmap_allocation_map_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap allocation map testbench
// Drives test, set, clear and find-first requests into the bitmap allocation
// map under several bytes-in-use settings. A scoreboard keeps its own copy of
// the bit map and predicts every response, which is checked field by field.
// ----------------------------------------------------------------------------
module bitmap_allocation_map_tb;
  import bam_pkg::*;

  localparam int MAP_BYTES  = MAP_BYTES_DEF;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 195;
  // Length of the long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 160;
  // Settle time at the end of the run, long enough to cover a find.
  localparam int SETTLE_CYCLES = 80;

  // Expected response of one request.
  typedef struct packed {
    logic [8:0] found_position;
    logic       bit_value;
    status_t    status;
  } response_t;

  // Scoreboard: a private copy of the bit map and the bytes-in-use register,
  // plus the queue of responses that are still owed by the block.
  class bitmap_ledger;
    logic [7:0] map_bytes [MAP_BYTES];
    logic [6:0] extent;
    response_t  owed_q [$];
    int         errors;

    function new();
      foreach (map_bytes[i]) map_bytes[i] = 8'h00;
      extent = BYTES_IN_USE_RST;
      errors = 0;
    endfunction

    function void set_extent(input logic [6:0] value);
      extent = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Works out the response to an accepted request and updates the map.
    function void note_request(input mode_t mode, input logic [8:0] pos,
                               input logic want);
      response_t   resp;
      int unsigned bits;
      int unsigned span;
      bits = ((extent > MAP_BYTES) ? MAP_BYTES : int'(extent)) * 8;
      span = (bits < 512) ? bits : 512;
      resp.status         = STAT_OK;
      resp.bit_value      = 1'b0;
      resp.found_position = 9'd0;
      if (mode == MODE_FIND) begin
        resp.status = STAT_NOT_FOUND;
        for (int q = 0; q < span; q++) begin
          if (map_bytes[q >> 3][q & 7] == want) begin
            resp.status         = STAT_OK;
            resp.found_position = q[8:0];
            break;
          end
        end
      end else if (pos >= bits) begin
        resp.status = STAT_RANGE;
      end else begin
        case (mode)
          MODE_TEST:  resp.bit_value = map_bytes[pos >> 3][pos[2:0]];
          MODE_SET:   map_bytes[pos >> 3][pos[2:0]] = 1'b1;
          MODE_CLEAR: map_bytes[pos >> 3][pos[2:0]] = 1'b0;
          default: ;
        endcase
      end
      owed_q.push_back(resp);
    endfunction

    // Compares one accepted response with the oldest one owed.
    function void check_response(input logic [15:0] data);
      response_t owed;
      if (owed_q.size() == 0) begin
        $error("response %h arrived with none outstanding", data);
        errors++;
        return;
      end
      owed = owed_q.pop_front();
      if (data[1:0] !== owed.status) begin
        $error("status: expected %0d, actual %0d", owed.status, data[1:0]);
        errors++;
      end
      if (data[2] !== owed.bit_value) begin
        $error("bit_value: expected %0d, actual %0d", owed.bit_value, data[2]);
        errors++;
      end
      if (data[11:3] !== owed.found_position) begin
        $error("found_position: expected %0d, actual %0d",
               owed.found_position, data[11:3]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [1:0] mode, [10:2] position, [11] find_value
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [1:0] status, [2] bit_value, [11:3] found_position
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  bitmap_ledger ledger;

  // Idle rates of the two sides, in percent, changed from phase to phase.
  int send_idle_pct;
  int recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic hold_requested;

  bitmap_allocation_map DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one request and waits until the block accepts the transaction.
  // The valid is only lowered when an idle gap is actually taken, so that a
  // back-to-back request never sees a low and a high in the same time step.
  task automatic send_request(input mode_t mode, input logic [8:0] pos,
                              input logic want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, want, pos, mode};
    do @(posedge clk); while (!in_tready);
    ledger.note_request(mode, pos, want);
  endtask

  // Stops offering requests until every owed response has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Writes the bytes-in-use register once the block has gone quiet.
  task automatic write_extent(input logic [6:0] value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.set_extent(value);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request while
  // the sender keeps going, which fills the block and stalls its input.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every response transaction is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ledger.check_response(out_tdata);
    end
  end

  initial begin
    logic [6:0]  extents [NUM_PHASES];
    int unsigned bits;
    int unsigned pos_hi;
    int unsigned pick;
    int          set_pct;
    int          clear_pct;
    mode_t       mode;
    logic [8:0]  pos;

    extents = '{7'd2, 7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd32, 7'd3, 7'd65, 7'd64};
    ledger         = new();
    hold_requested = 1'b0;
    send_idle_pct  = 34;
    recv_idle_pct  = 73;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 16'h0000;
    cfg_valid <= 1'b0;
    cfg_data  <= 7'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the whole map in use as after reset. Fields
    // that a mode ignores are given awkward values on purpose.
    send_request(MODE_TEST,  9'd0,   1'b1);
    send_request(MODE_TEST,  9'd511, 1'b0);
    send_request(MODE_SET,   9'd0,   1'b1);
    send_request(MODE_SET,   9'd511, 1'b0);
    send_request(MODE_TEST,  9'd511, 1'b1);
    send_request(MODE_FIND,  9'd511, 1'b1);
    send_request(MODE_FIND,  9'd0,   1'b0);
    send_request(MODE_CLEAR, 9'd0,   1'b1);
    // Only bit 511 is left, so the find for a one scans the whole map.
    send_request(MODE_FIND,  9'd0,   1'b1);

    // One byte in use: positions from eight upwards are out of range, and a
    // find for a zero comes back empty once the byte is full.
    write_extent(7'd1);
    send_request(MODE_SET,   9'd9,   1'b0);
    send_request(MODE_CLEAR, 9'd8,   1'b0);
    send_request(MODE_TEST,  9'd511, 1'b0);
    send_request(MODE_FIND,  9'd0,   1'b1);
    for (int b = 0; b < 8; b++) send_request(MODE_SET, 9'(b), 1'b0);
    send_request(MODE_FIND,  9'd0,   1'b0);

    // No bytes in use at all.
    write_extent(7'd0);
    send_request(MODE_TEST,  9'd0,   1'b0);
    send_request(MODE_FIND,  9'd0,   1'b1);

    // Register above the map size: treated as the full map.
    write_extent(7'd127);
    send_request(MODE_FIND,  9'd0,   1'b1);
    send_request(MODE_TEST,  9'd511, 1'b0);

    // Random part. Odd phases lean towards setting bits so that finds for a
    // zero have to search, even phases lean towards clearing them so that
    // finds for a one run deep into the map.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 34;
        recv_idle_pct = 73;
      end else if (ph < 7) begin
        send_idle_pct = 73;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_extent(extents[ph]);
      bits      = ((extents[ph] > MAP_BYTES) ? MAP_BYTES : int'(extents[ph])) * 8;
      pos_hi    = (bits == 0) ? 15 : ((bits + 7 > 511) ? 511 : bits + 7);
      set_pct   = (ph % 2 == 1) ? 50 : 15;
      clear_pct = (ph % 2 == 1) ? 10 : 35;
      if (ph == 3) hold_requested = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through one phase the sender lets the block empty out.
        if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained();
        pick = $urandom_range(99);
        if (pick < 20) mode = MODE_TEST;
        else if (pick < 20 + set_pct) mode = MODE_SET;
        else if (pick < 20 + set_pct + clear_pct) mode = MODE_CLEAR;
        else mode = MODE_FIND;
        if ($urandom_range(4) == 0) pos = 9'($urandom_range(511));
        else pos = 9'($urandom_range(pos_hi));
        send_request(mode, pos, 1'($urandom_range(1)));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hang; far beyond the slowest correct run.
  initial begin
    #9600000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/bam_pkg.sv
rtl/bam_ram.sv
rtl/bitmap_allocation_map.sv
test/bitmap_allocation_map_tb.sv
